// ----- rtl/core/apdu_pkg.sv -----
// shared types and constants for the apdu chained frame reassembler
`default_nettype none

package apdu_pkg;

   // result status codes
   localparam logic [2:0] ST_MORE         = 3'd0;
   localparam logic [2:0] ST_COMPLETE     = 3'd1;
   localparam logic [2:0] ST_WRONG_LENGTH = 3'd2;
   localparam logic [2:0] ST_NOT_SELECTED = 3'd3;
   localparam logic [2:0] ST_OVERFLOW     = 3'd4;
   localparam logic [2:0] ST_READ_DATA    = 3'd5;

   // request function codes
   localparam logic FN_FRAME_BYTE = 1'b0;
   localparam logic FN_READ       = 1'b1;

   // header byte positions within a frame
   localparam logic [16:0] IDX_CLASS = 17'd0;
   localparam logic [16:0] IDX_INSTR = 17'd1;
   localparam logic [16:0] IDX_P1    = 17'd2;
   localparam logic [16:0] IDX_P2    = 17'd3;
   localparam logic [16:0] IDX_LEN   = 17'd4;

   // header sizes and footer sizes
   localparam logic [16:0] SHORT_HDR_LEN = 17'd5;
   localparam logic [16:0] EXT_HDR_LEN   = 17'd7;
   localparam logic [16:0] SHORT_FOOT    = 17'd1;
   localparam logic [16:0] EXT_FOOT      = 17'd2;

   localparam logic [7:0]  CLA_CHAIN_BIT = 8'h10;
   localparam logic [16:0] CNT_MAX       = 17'h1FFFF;
   localparam logic [15:0] LE_SHORT_MASK = 16'h00FF;

   typedef struct packed {
      logic        func;
      logic [7:0]  frame_byte;
      logic        frame_end;
      logic [10:0] read_addr;
      logic        app_is_fido;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  class_byte;
      logic [7:0]  instruction;
      logic [7:0]  param_one;
      logic [7:0]  param_two;
      logic [11:0] msg_length;
      logic [15:0] expected_reply;
      logic [7:0]  read_data;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/apdu_chained_frame_reassembler_core.sv -----
// apdu command chaining reassembler: frame parsing, payload buffer and result pipeline
`default_nettype none

// Takes one request transfer per cycle while the result stage is free to move: either a
// frame byte or a buffer read. Frame bytes update the header and count registers and write
// payload bytes straight into a BUF_DEPTH-byte synchronous buffer; the last byte of a frame
// yields a status result. A read yields the stored byte. A result passes the stage register,
// which waits for the registered buffer read, then the output register; the two let a new
// request be taken while a result waits. Sustained rate is one item per cycle while rsp_ready
// stays high. Reading a buffer position that was never written returns an unspecified byte.
module apdu_chained_frame_reassembler_core #(
   parameter int BUF_DEPTH = 2048
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  apdu_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output apdu_pkg::rsp_type    rsp_data
);

   import apdu_pkg::*;

   localparam int AW    = $clog2(BUF_DEPTH);
   localparam int ACC_W = $clog2(BUF_DEPTH + 1);
   localparam logic [17:0] DEPTH_W = 18'(BUF_DEPTH);

   // frame state
   logic [16:0]      byte_count_ff, byte_count_in;
   logic [7:0]       hdr_class_ff, hdr_class_in;
   logic [7:0]       hdr_instr_ff, hdr_instr_in;
   logic [7:0]       hdr_p1_ff, hdr_p1_in;
   logic [7:0]       hdr_p2_ff, hdr_p2_in;
   logic [7:0]       hdr_short_len_ff, hdr_short_len_in;
   logic [15:0]      ext_len_ff, ext_len_in;
   logic [15:0]      tail_bytes_ff, tail_bytes_in;
   logic [ACC_W-1:0] acc_length_ff, acc_length_in;

   // buffer
   logic [7:0]       payload_mem [BUF_DEPTH];
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [AW-1:0]    mem_raddr;
   logic             mem_re;
   logic [7:0]       mem_q_ff;

   // pipeline
   logic             s1_valid_ff;
   rsp_type          s1_rsp_ff;
   logic             s1_rd_ff;
   logic             s1_in_range_ff;
   rsp_type          s1_res_c;
   logic             out_valid_ff;
   rsp_type          out_rsp_ff;

   logic             req_accept;
   logic             s1_move;
   logic             s1_load;
   logic             rd_in_range;
   logic [16:0]      rd_addr_wide;
   rsp_type          res_c;

   // frame evaluation intermediates
   logic [16:0]      hdr_len;
   logic [16:0]      pay_off;
   logic [17:0]      wr_pos;
   logic             fin;
   logic             ext;
   logic [16:0]      end_hdr;
   logic [16:0]      end_foot;
   logic [16:0]      hdr_foot;
   logic [15:0]      stated;
   logic [17:0]      acc_sum;
   logic             len_bad;

   // handshake
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_move;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_rsp_ff;

   // read address decode
   assign rd_addr_wide = {6'd0, req_data.read_addr};
   assign rd_in_range  = {1'b0, rd_addr_wide} < DEPTH_W;
   assign mem_raddr    = rd_addr_wide[AW-1:0];
   assign mem_re       = req_accept && (req_data.func == FN_READ);

   // frame byte parsing, length checks and result forming
   always_comb begin
      byte_count_in    = byte_count_ff;
      hdr_class_in     = hdr_class_ff;
      hdr_instr_in     = hdr_instr_ff;
      hdr_p1_in        = hdr_p1_ff;
      hdr_p2_in        = hdr_p2_ff;
      hdr_short_len_in = hdr_short_len_ff;
      ext_len_in       = ext_len_ff;
      tail_bytes_in    = tail_bytes_ff;
      acc_length_in    = acc_length_ff;
      mem_we           = 1'b0;
      s1_load          = 1'b0;
      res_c            = '0;

      hdr_len = (byte_count_ff >= SHORT_HDR_LEN && hdr_short_len_ff == 8'd0)
                ? EXT_HDR_LEN : SHORT_HDR_LEN;
      pay_off   = byte_count_ff - hdr_len;
      wr_pos    = {{(18 - ACC_W){1'b0}}, acc_length_ff} + {1'b0, pay_off};
      mem_waddr = wr_pos[AW-1:0];

      if (req_accept && req_data.func == FN_FRAME_BYTE) begin
         // store the byte where its position says
         if (byte_count_ff == IDX_CLASS) begin
            hdr_class_in = req_data.frame_byte;
         end else if (byte_count_ff == IDX_INSTR) begin
            hdr_instr_in = req_data.frame_byte;
         end else if (byte_count_ff == IDX_P1) begin
            hdr_p1_in = req_data.frame_byte;
         end else if (byte_count_ff == IDX_P2) begin
            hdr_p2_in = req_data.frame_byte;
         end else if (byte_count_ff == IDX_LEN) begin
            hdr_short_len_in = req_data.frame_byte;
         end else if (byte_count_ff < hdr_len) begin
            ext_len_in = {ext_len_ff[7:0], req_data.frame_byte};
         end else begin
            mem_we = wr_pos < DEPTH_W;
         end
         tail_bytes_in = {tail_bytes_ff[7:0], req_data.frame_byte};
         if (byte_count_ff != CNT_MAX) begin
            byte_count_in = byte_count_ff + 17'd1;
         end
      end

      // frame end checks on the updated frame state
      fin      = (hdr_class_in & CLA_CHAIN_BIT) == 8'd0;
      ext      = (byte_count_in >= SHORT_HDR_LEN) && (hdr_short_len_in == 8'd0);
      end_hdr  = ext ? EXT_HDR_LEN : SHORT_HDR_LEN;
      end_foot = fin ? (ext ? EXT_FOOT : SHORT_FOOT) : 17'd0;
      hdr_foot = end_hdr + end_foot;
      stated   = ext ? ext_len_in : {8'd0, hdr_short_len_in};
      len_bad  = (byte_count_in < SHORT_HDR_LEN) || (byte_count_in < hdr_foot)
                 || ((byte_count_in - hdr_foot) != {1'b0, stated});
      acc_sum  = {{(18 - ACC_W){1'b0}}, acc_length_ff} + {2'b0, stated};

      if (req_accept && req_data.func == FN_READ) begin
         s1_load      = 1'b1;
         res_c.status = ST_READ_DATA;
      end else if (req_accept && req_data.frame_end) begin
         s1_load = 1'b1;
         if (!req_data.app_is_fido) begin
            res_c.status = ST_NOT_SELECTED;
         end else if (len_bad) begin
            res_c.status = ST_WRONG_LENGTH;
         end else if (acc_sum > DEPTH_W) begin
            res_c.status = ST_OVERFLOW;
         end else if (fin) begin
            res_c.status         = ST_COMPLETE;
            res_c.class_byte     = hdr_class_in;
            res_c.instruction    = hdr_instr_in;
            res_c.param_one      = hdr_p1_in;
            res_c.param_two      = hdr_p2_in;
            res_c.msg_length     = acc_sum[11:0];
            res_c.expected_reply = ext ? tail_bytes_in : (tail_bytes_in & LE_SHORT_MASK);
            acc_length_in        = '0;
         end else begin
            res_c.status     = ST_MORE;
            res_c.msg_length = acc_sum[11:0];
            acc_length_in    = acc_sum[ACC_W-1:0];
         end
         // every frame end starts a fresh frame
         byte_count_in    = '0;
         hdr_class_in     = '0;
         hdr_instr_in     = '0;
         hdr_p1_in        = '0;
         hdr_p2_in        = '0;
         hdr_short_len_in = '0;
         ext_len_in       = '0;
         tail_bytes_in    = '0;
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= '0;
         hdr_class_ff     <= '0;
         hdr_instr_ff     <= '0;
         hdr_p1_ff        <= '0;
         hdr_p2_ff        <= '0;
         hdr_short_len_ff <= '0;
         ext_len_ff       <= '0;
         tail_bytes_ff    <= '0;
         acc_length_ff    <= '0;
      end else begin
         byte_count_ff    <= byte_count_in;
         hdr_class_ff     <= hdr_class_in;
         hdr_instr_ff     <= hdr_instr_in;
         hdr_p1_ff        <= hdr_p1_in;
         hdr_p2_ff        <= hdr_p2_in;
         hdr_short_len_ff <= hdr_short_len_in;
         ext_len_ff       <= ext_len_in;
         tail_bytes_ff    <= tail_bytes_in;
         acc_length_ff    <= acc_length_in;
      end
   end

   // payload buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         payload_mem[mem_waddr] <= req_data.frame_byte;
      end
      if (mem_re) begin
         mem_q_ff <= payload_mem[mem_raddr];
      end
   end

   // result stage, waits for the buffer read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
      if (s1_load) begin
         s1_rsp_ff      <= res_c;
         s1_rd_ff       <= req_data.func == FN_READ;
         s1_in_range_ff <= rd_in_range;
      end
   end

   // read data joins the stage result on its way out
   always_comb begin
      s1_res_c           = s1_rsp_ff;
      s1_res_c.read_data = (s1_rd_ff && s1_in_range_ff) ? mem_q_ff : 8'd0;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (s1_move) begin
         out_rsp_ff <= s1_res_c;
      end
   end

`ifndef SYNTHESIS
   a_acc_bounded: assert property (@(posedge clock) disable iff (reset)
      {{(18 - ACC_W){1'b0}}, acc_length_ff} <= DEPTH_W)
      else $error("accumulated length beyond buffer depth");

   a_no_stage_overrun: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!s1_valid_ff || s1_move))
      else $error("result stage overwritten");

   a_complete_clears_acc: assert property (@(posedge clock) disable iff (reset)
      (s1_load && res_c.status == ST_COMPLETE) |=> acc_length_ff == '0)
      else $error("complete chain left accumulated length");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.func == FN_FRAME_BYTE && req_data.frame_end)
      |=> byte_count_ff == '0)
      else $error("frame end did not clear byte count");
`endif

endmodule

`default_nettype wire

// ----- dv/apdu_reassembly_checker.sv -----
// result checker for the apdu chained frame reassembler: predicts and compares results
module apdu_reassembly_checker #(
   parameter int BUF_DEPTH = 2048
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  apdu_pkg::req_type  req_data,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  apdu_pkg::rsp_type  rsp_data,
   output int                 fail_count,
   output int                 pending_results,
   output int                 written_span
);
   timeunit 1ns;
   timeprecision 1ps;

   import apdu_pkg::*;

   // shadow copy of the frame parser and the payload buffer
   logic [16:0] frame_count;
   logic [7:0]  cls_q;
   logic [7:0]  ins_q;
   logic [7:0]  p1_q;
   logic [7:0]  p2_q;
   logic [7:0]  len_q;
   logic [15:0] ext_len_q;
   logic [15:0] tail_q;
   int          chain_len;
   logic [7:0]  payload_mem [BUF_DEPTH];

   // results still owed by the block, oldest first
   rsp_type     awaited_results [$];

   task report_mismatch(input string what);
      if (fail_count < 40) $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   task clear_frame_state();
      frame_count = '0;
      cls_q       = '0;
      ins_q       = '0;
      p1_q        = '0;
      p2_q        = '0;
      len_q       = '0;
      ext_len_q   = '0;
      tail_q      = '0;
   endtask

   // one request transfer: a buffer read, or a frame byte that may close the frame
   task reassemble_step(input req_type r);
      rsp_type res;
      int      idx;
      int      hdr_sz;
      int      foot_sz;
      int      stated;
      int      pos;
      bit      is_final;
      bit      is_ext;
      res = '0;
      if (r.func == FN_READ) begin
         res.status = ST_READ_DATA;
         if (r.read_addr < BUF_DEPTH) res.read_data = payload_mem[r.read_addr];
         awaited_results.push_back(res);
      end else begin
         // header capture, extended length, then payload and footer into the buffer
         idx    = frame_count;
         hdr_sz = (idx >= 5 && len_q == 8'h00) ? EXT_HDR_LEN : SHORT_HDR_LEN;
         if (idx == IDX_CLASS) cls_q = r.frame_byte;
         else if (idx == IDX_INSTR) ins_q = r.frame_byte;
         else if (idx == IDX_P1) p1_q = r.frame_byte;
         else if (idx == IDX_P2) p2_q = r.frame_byte;
         else if (idx == IDX_LEN) len_q = r.frame_byte;
         else if (idx < hdr_sz) ext_len_q = {ext_len_q[7:0], r.frame_byte};
         else begin
            pos = chain_len + idx - hdr_sz;
            if (pos < BUF_DEPTH) begin
               payload_mem[pos] = r.frame_byte;
               if (pos >= written_span) written_span = pos + 1;
            end
         end
         tail_q = {tail_q[7:0], r.frame_byte};
         if (frame_count != CNT_MAX) frame_count++;

         // frame close: selection, length, then buffer space
         if (r.frame_end) begin
            idx      = frame_count;
            is_final = (cls_q & CLA_CHAIN_BIT) == 8'h00;
            is_ext   = (idx >= 5) && (len_q == 8'h00);
            hdr_sz   = is_ext ? EXT_HDR_LEN : SHORT_HDR_LEN;
            foot_sz  = is_final ? (is_ext ? EXT_FOOT : SHORT_FOOT) : 0;
            stated   = is_ext ? int'(ext_len_q) : int'(len_q);
            if (!r.app_is_fido) begin
               res.status = ST_NOT_SELECTED;
            end else if (idx < 5 || idx < hdr_sz + foot_sz
                         || idx - hdr_sz - foot_sz != stated) begin
               res.status = ST_WRONG_LENGTH;
            end else if (chain_len + stated > BUF_DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               chain_len      = chain_len + stated;
               res.msg_length = chain_len[11:0];
               if (is_final) begin
                  res.status         = ST_COMPLETE;
                  res.class_byte     = cls_q;
                  res.instruction    = ins_q;
                  res.param_one      = p1_q;
                  res.param_two      = p2_q;
                  res.expected_reply = is_ext ? tail_q : (tail_q & LE_SHORT_MASK);
                  chain_len          = 0;
               end else begin
                  res.status = ST_MORE;
               end
            end
            awaited_results.push_back(res);
            clear_frame_state();
         end
      end
   endtask

   // compare one result transfer with the oldest prediction
   task check_result(input rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch($sformatf("result with status %0d while none awaited", got.status));
      end else begin
         want = awaited_results.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.class_byte !== want.class_byte)
            report_mismatch($sformatf("class_byte %0h, want %0h",
                                      got.class_byte, want.class_byte));
         if (got.instruction !== want.instruction)
            report_mismatch($sformatf("instruction %0h, want %0h",
                                      got.instruction, want.instruction));
         if (got.param_one !== want.param_one)
            report_mismatch($sformatf("param_one %0h, want %0h",
                                      got.param_one, want.param_one));
         if (got.param_two !== want.param_two)
            report_mismatch($sformatf("param_two %0h, want %0h",
                                      got.param_two, want.param_two));
         if (got.msg_length !== want.msg_length)
            report_mismatch($sformatf("msg_length %0d, want %0d",
                                      got.msg_length, want.msg_length));
         if (got.expected_reply !== want.expected_reply)
            report_mismatch($sformatf("expected_reply %0h, want %0h",
                                      got.expected_reply, want.expected_reply));
         if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %0h, want %0h",
                                      got.read_data, want.read_data));
      end
   endtask

   // watch both channels on every rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_frame_state();
         chain_len    = 0;
         fail_count   = 0;
         written_span = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) reassemble_step(req_data);
      end
      pending_results = awaited_results.size();
   end

endmodule

// ----- dv/tb_apdu_chained_frame_reassembler_core.sv -----
// testbench top for the apdu chained frame reassembler: stimulus, stalls and verdict
module tb_apdu_chained_frame_reassembler_core;
   timeunit 1ns;
   timeprecision 1ps;

   import apdu_pkg::*;

   localparam int DEPTH        = 2048;
   localparam int RANDOM_ITEMS = 400;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending_results;
   int written_span;

   // bytes of the frame about to be sent
   logic [7:0] frame_bytes [$];

   int items_sent = 0;
   int burst_left = 0;
   bit gapless    = 1'b0;

   // receiver stall pattern state
   int stall_mode = 0;
   int mode_left  = 0;
   int hold_left  = 0;
   bit stalled    = 1'b0;

   always #2 clock = ~clock;

   apdu_chained_frame_reassembler_core #(
      .BUF_DEPTH(DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   apdu_reassembly_checker #(
      .BUF_DEPTH(DEPTH)
   ) result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending_results(pending_results),
      .written_span   (written_span)
   );

   // receiver: always ready, random stalls, or long stalls, switching now and then
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: begin
            if (hold_left == 0) begin
               stalled   = !stalled;
               hold_left = stalled ? $urandom_range(1, 12) : $urandom_range(1, 4);
            end else begin
               hold_left--;
            end
            rsp_ready <= !stalled;
         end
      endcase
   end

   // one request transfer, then maybe a gap that closes the burst
   task send_request(input req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (!gapless && burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap        = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   task send_read(input logic [10:0] addr);
      req_type item;
      item.func        = FN_READ;
      item.frame_byte  = 8'($urandom_range(0, 255));
      item.frame_end   = 1'($urandom_range(0, 1));
      item.read_addr   = addr;
      item.app_is_fido = 1'($urandom_range(0, 1));
      send_request(item);
   endtask

   // hold off the sender until every result has come back
   task drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // header, length field, payload with an optional count error, footer on final frames
   task build_frame(input logic [7:0] cls, input logic [7:0] ins, input logic [7:0] p1,
                    input logic [7:0] p2, input bit ext, input int stated, input int skew);
      int body;
      frame_bytes.delete();
      frame_bytes.push_back(cls);
      frame_bytes.push_back(ins);
      frame_bytes.push_back(p1);
      frame_bytes.push_back(p2);
      if (ext) begin
         frame_bytes.push_back(8'h00);
         frame_bytes.push_back(stated[15:8]);
         frame_bytes.push_back(stated[7:0]);
      end else begin
         frame_bytes.push_back(stated[7:0]);
      end
      body = stated + skew;
      if (body < 0) body = 0;
      repeat (body) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if ((cls & CLA_CHAIN_BIT) == 8'h00)
         repeat (ext ? 2 : 1) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task build_runt(input int len);
      frame_bytes.delete();
      repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // send the built frame, with buffer reads mixed in between its bytes
   task send_frame(input bit fido, input int read_pct);
      req_type item;
      for (int k = 0; k < frame_bytes.size(); k++) begin
         if (written_span > 0 && $urandom_range(0, 99) < read_pct)
            send_read(11'($urandom_range(0, written_span - 1)));
         item.func        = FN_FRAME_BYTE;
         item.frame_byte  = frame_bytes[k];
         item.frame_end   = (k == frame_bytes.size() - 1);
         item.read_addr   = 11'($urandom_range(0, 2047));
         item.app_is_fido = item.frame_end ? fido : 1'($urandom_range(0, 1));
         send_request(item);
      end
   endtask

   // mostly small lengths, now and then the extremes
   function int pick_stated(input bit ext);
      int r;
      r = $urandom_range(0, 19);
      if (ext) begin
         if (r == 0) return $urandom_range(256, 700);
         if (r < 3) return 0;
         return $urandom_range(0, 40);
      end
      if (r == 0) return $urandom_range(17, 255);
      return $urandom_range(1, 16);
   endfunction

   // a chain of non-final frames closed by a final frame, rarely broken
   task send_chain();
      int         links;
      int         skew;
      bit         fido;
      bit         ext;
      logic [7:0] cls;
      links = $urandom_range(0, 3);
      for (int k = 0; k <= links; k++) begin
         cls    = 8'($urandom_range(0, 255));
         cls[4] = (k != links);
         ext    = ($urandom_range(0, 3) == 0);
         skew   = ($urandom_range(0, 24) == 0) ? ($urandom_range(0, 1) ? 1 : -1) : 0;
         fido   = ($urandom_range(0, 24) != 0);
         build_frame(cls, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), ext, pick_stated(ext), skew);
         send_frame(fido, 10);
      end
   endtask

   // runts, miscounted frames, unselected frames and read bursts
   task send_noise();
      bit ext;
      ext = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: begin
            build_runt($urandom_range(1, 8));
            send_frame(1'b1, 0);
         end
         1: begin
            build_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        ext, pick_stated(ext), int'($urandom_range(0, 4)) - 2);
            send_frame(1'($urandom_range(0, 1)), 20);
         end
         2: begin
            build_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        ext, pick_stated(ext), 0);
            send_frame(1'b0, 0);
         end
         default: begin
            if (written_span > 0)
               repeat ($urandom_range(1, 6)) send_read(11'($urandom_range(0, written_span - 1)));
         end
      endcase
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // not selected, runt, miscounted short frame
      build_frame(8'h00, 8'hA4, 8'h04, 8'h00, 1'b0, 3, 0);
      send_frame(1'b0, 0);
      build_runt(3);
      send_frame(1'b1, 0);
      build_frame(8'h00, 8'h10, 8'h01, 8'h02, 1'b0, 4, 1);
      send_frame(1'b1, 0);

      // two-frame chain, then read back what it left
      build_frame(8'h10, 8'h2A, 8'h80, 8'h86, 1'b0, 3, 0);
      send_frame(1'b1, 0);
      build_frame(8'h00, 8'h2A, 8'h80, 8'h86, 1'b0, 2, 0);
      send_frame(1'b1, 0);
      for (int k = 0; k < 5; k++) send_read(11'(k));

      // fill the whole buffer, overflow it, then close the chain at full length
      build_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, DEPTH, 0);
      send_frame(1'b1, 2);
      build_frame(8'h10, 8'h01, 8'h02, 8'h03, 1'b0, 1, 0);
      send_frame(1'b1, 0);
      build_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 0, 0);
      frame_bytes[frame_bytes.size() - 1] = 8'hFF;
      frame_bytes[frame_bytes.size() - 2] = 8'hFF;
      send_frame(1'b1, 0);
      send_read(11'h7FF);
      send_read(11'h000);
      send_read(11'h400);
      send_read(11'h3FF);
      drain_results();

      // random chains and noise
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         gapless = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 3) != 0) send_chain();
         else send_noise();
         if ($urandom_range(0, 9) == 0) drain_results();
      end
      gapless = 1'b0;
      drain_results();
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
